### src/wpf_pkg.sv
// Shared types, codes and constants of the waypoint follower.
package wpf_pkg;

    typedef enum logic [1:0] {
        REQ_WAYPOINT = 2'd0,
        REQ_GOAL     = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_MAX_LINEAR = 2'd0,
        CFG_MAX_TURN   = 2'd1,
        CFG_FRAME_RATE = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_ORIGIN,
        MODE_XZERO,
        MODE_TRACK
    } mode_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ITER,
        B_ANGLE,
        B_MUL_ANG,
        B_MUL_LIN,
        B_FINISH
    } back_state_t;

    typedef struct packed {
        logic [30:0] max_linear;
        logic [30:0] max_turn;
        logic [15:0] frame_rate;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               stop;
        mode_t              mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_slot_t;

    localparam int FIFO_DEPTH = 2;
    localparam int CORDIC_W   = 52;

    localparam logic signed [31:0] PI_Q16      = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;

    function automatic logic [15:0] atan_entry(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### src/wpf_if.sv
// Valid/ready channels for request items and velocity commands.
interface wpf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic               in_base_frame;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               goal_flag;

    modport source (output valid, req_type, in_base_frame, pos_x, pos_y, quat_z, quat_w,
                    goal_flag, input ready);
    modport sink (input valid, req_type, in_base_frame, pos_x, pos_y, quat_z, quat_w,
                  goal_flag, output ready);
endinterface

interface wpf_cmd_if;
    logic               valid;
    logic               ready;
    logic [30:0]        linear_cmd;
    logic signed [31:0] angular_cmd;

    modport source (output valid, linear_cmd, angular_cmd, input ready);
    modport sink (input valid, linear_cmd, angular_cmd, output ready);
endinterface

### src/wpf_fifo.sv
// Short job queue between the request front end and the command back end.
module wpf_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  wpf_pkg::job_slot_t push,
    output logic              full,
    output wpf_pkg::job_slot_t head,
    input  logic              pop
);
    import wpf_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    job_t          mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

endmodule

### src/wpf_front.sv
// Request front end: holds the waypoint, goal latch and age, and queues one job per tick.
module wpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  wpf_pkg::cfg_t      cfg,
    wpf_req_if.sink            request,
    input  logic               full,
    output wpf_pkg::job_slot_t push
);
    import wpf_pkg::*;

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [15:0] qz_reg;
    logic signed [15:0] qw_reg;
    logic               have_reg;
    logic               goal_reg;
    logic [15:0]        ticks_reg;
    logic               have_next;
    logic               goal_next;
    logic [15:0]        ticks_next;
    logic [15:0]        ticks_inc;
    logic               accept;
    logic               take_wp;

    assign request.ready = !full;
    assign accept        = request.valid && request.ready;
    assign take_wp       = accept && (request.req_type == REQ_WAYPOINT) && request.in_base_frame;
    assign ticks_inc     = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    always_comb
    begin
        have_next  = have_reg;
        goal_next  = goal_reg;
        ticks_next = ticks_reg;
        if (take_wp)
        begin
            have_next  = 1'b1;
            ticks_next = '0;
        end
        if (accept && (request.req_type == REQ_GOAL) && request.goal_flag)
        begin
            goal_next = 1'b1;
        end
        if (accept && (request.req_type == REQ_TICK))
        begin
            ticks_next = ticks_inc;
        end
    end

    always_comb
    begin
        push.valid    = accept && (request.req_type == REQ_TICK);
        push.job.stop = goal_reg || !have_reg || (ticks_inc > cfg.timeout_ticks);
        push.job.x    = x_reg;
        push.job.y    = y_reg;
        push.job.qz   = qz_reg;
        push.job.qw   = qw_reg;
        if (x_reg == '0 && y_reg == '0)
        begin
            push.job.mode = MODE_ORIGIN;
        end
        else if (x_reg == '0)
        begin
            push.job.mode = MODE_XZERO;
        end
        else
        begin
            push.job.mode = MODE_TRACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            goal_reg  <= 1'b0;
            ticks_reg <= '0;
        end
        else
        begin
            have_reg  <= have_next;
            goal_reg  <= goal_next;
            ticks_reg <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_wp)
        begin
            x_reg  <= request.pos_x;
            y_reg  <= request.pos_y;
            qz_reg <= request.quat_z;
            qw_reg <= request.quat_w;
        end
    end

endmodule

### src/wpf_back.sv
// Command back end: iterative CORDIC heading, rate scaling, saturation and clamping.
module wpf_back #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wpf_pkg::cfg_t      cfg,
    input  wpf_pkg::job_slot_t head,
    output logic               pop,
    wpf_cmd_if.source          command
);
    import wpf_pkg::*;

    localparam int SW  = $clog2(CORDIC_STEPS);
    localparam int LSH = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
    localparam int RSH = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

    back_state_t                state_reg;
    back_state_t                state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    mode_t                      mode_reg;
    logic                       stop_reg;
    logic signed [32:0]         lx_reg;
    logic signed [CORDIC_W-1:0] cx_reg;
    logic signed [CORDIC_W-1:0] cy_reg;
    logic signed [31:0]         z_reg;
    logic [SW-1:0]              step_reg;
    logic signed [32:0]         ang_reg;
    logic signed [49:0]         prod_reg;
    logic signed [31:0]         ang_res_reg;
    logic [30:0]                lin_out_reg;
    logic signed [31:0]         ang_out_reg;

    logic                       out_free;
    logic                       load_out;
    logic signed [32:0]         xin;
    logic signed [32:0]         yin;
    logic signed [32:0]         xr;
    logic signed [32:0]         yr;
    logic signed [31:0]         z0;
    logic signed [CORDIC_W-1:0] cx_next;
    logic signed [CORDIC_W-1:0] cy_next;
    logic signed [31:0]         z_next;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [31:0]         atan_v;
    logic signed [32:0]         ang_pre;
    logic signed [32:0]         ang_next;
    logic [30:0]                lin_fin;
    logic signed [31:0]         ang_fin;

    function automatic logic signed [31:0] sat_q(input logic signed [49:0] p);
        logic signed [41:0] v;
        logic signed [31:0] r;
        v = 42'(p >>> 8);
        if (v > $signed({10'd0, 32'h7FFF_FFFF}))
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < $signed({10'h3FF, 32'h8000_0000}))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] clamp_lin(input logic signed [31:0] v,
                                               input logic [30:0] m);
        logic [30:0] r;
        if (v[31])
        begin
            r = '0;
        end
        else if (v[30:0] > m)
        begin
            r = m;
        end
        else
        begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_ang(input logic signed [31:0] v,
                                                      input logic [30:0] m);
        logic signed [32:0] vv;
        logic signed [32:0] pl;
        logic signed [32:0] nl;
        logic signed [31:0] r;
        vv = {v[31], v};
        pl = $signed({2'b00, m});
        nl = -pl;
        if (vv > pl)
        begin
            r = pl[31:0];
        end
        else if (vv < nl)
        begin
            r = nl[31:0];
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign out_free      = !out_valid_reg || command.ready;
    assign command.valid       = out_valid_reg;
    assign command.linear_cmd  = lin_out_reg;
    assign command.angular_cmd = ang_out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.job.stop)
                    begin
                        state_next = B_FINISH;
                    end
                    else if (head.job.mode == MODE_XZERO)
                    begin
                        state_next = B_ANGLE;
                    end
                    else
                    begin
                        state_next = B_ITER;
                    end
                end
            end
            B_ITER:
            begin
                if (step_reg == SW'(CORDIC_STEPS - 1))
                begin
                    state_next = B_ANGLE;
                end
            end
            B_ANGLE:   state_next = B_MUL_ANG;
            B_MUL_ANG: state_next = B_MUL_LIN;
            B_MUL_LIN: state_next = B_FINISH;
            B_FINISH:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:   state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:   pop = head.valid;
            B_FINISH: load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // operand set-up with pre-rotation by pi
    always_comb
    begin
        if (head.job.mode == MODE_ORIGIN)
        begin
            xin = 33'(head.job.qw);
            yin = 33'(head.job.qz);
        end
        else if (head.job.x < 0)
        begin
            xin = -{head.job.x[31], head.job.x};
            yin = -{head.job.y[31], head.job.y};
        end
        else
        begin
            xin = {head.job.x[31], head.job.x};
            yin = {head.job.y[31], head.job.y};
        end
        if (xin < 0)
        begin
            z0 = (yin >= 0) ? PI_Q16 : -PI_Q16;
            xr = -xin;
            yr = -yin;
        end
        else
        begin
            z0 = '0;
            xr = xin;
            yr = yin;
        end
    end

    // one CORDIC step
    always_comb
    begin
        xs     = cx_reg >>> step_reg;
        ys     = cy_reg >>> step_reg;
        atan_v = $signed({16'd0, atan_entry(5'(step_reg))});
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next  = z_reg;
        if (cy_reg > 0)
        begin
            cx_next = cx_reg + ys;
            cy_next = cy_reg - xs;
            z_next  = z_reg + atan_v;
        end
        else if (cy_reg < 0)
        begin
            cx_next = cx_reg - ys;
            cy_next = cy_reg + xs;
            z_next  = z_reg - atan_v;
        end
    end

    always_comb
    begin
        ang_pre  = (mode_reg == MODE_ORIGIN) ? ({z_reg[31], z_reg} <<< 1) : {z_reg[31], z_reg};
        ang_next = (ang_pre <<< LSH) >>> RSH;
        lin_fin  = (stop_reg || mode_reg != MODE_TRACK) ? '0
                 : clamp_lin(sat_q(prod_reg), cfg.max_linear);
        ang_fin  = stop_reg ? '0 : ang_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (command.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    mode_reg <= head.job.mode;
                    stop_reg <= head.job.stop;
                    lx_reg   <= {head.job.x[31], head.job.x};
                    step_reg <= '0;
                    cx_reg   <= {{(CORDIC_W - 49){xr[32]}}, xr, 16'd0};
                    cy_reg   <= {{(CORDIC_W - 49){yr[32]}}, yr, 16'd0};
                    if (head.job.mode == MODE_XZERO)
                    begin
                        z_reg <= (head.job.y > 0) ? HALF_PI_Q16 : -HALF_PI_Q16;
                    end
                    else
                    begin
                        z_reg <= z0;
                    end
                end
            end
            B_ITER:
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                z_reg    <= z_next;
                step_reg <= step_reg + SW'(1);
            end
            B_ANGLE:
            begin
                ang_reg <= ang_next;
            end
            B_MUL_ANG:
            begin
                prod_reg <= ang_reg * $signed({1'b0, cfg.frame_rate});
            end
            B_MUL_LIN:
            begin
                ang_res_reg <= clamp_ang(sat_q(prod_reg), cfg.max_turn);
                prod_reg    <= lx_reg * $signed({1'b0, cfg.frame_rate});
            end
            B_FINISH:
            begin
                if (load_out)
                begin
                    lin_out_reg <= lin_fin;
                    ang_out_reg <= ang_fin;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

endmodule

### src/waypoint_to_velocity_follower_top.sv
// Top level of the waypoint follower: configuration registers and block assembly.
//
// The request channel takes waypoint, goal report and control tick items; a transfer
// happens when valid and ready are both high. Waypoints and goal reports only update
// internal state and give no command. Each control tick gives exactly one velocity
// command on the command channel, in order.
// Ticks are queued in a two-entry job queue; request ready is low only while that
// queue is full. The back end runs one job at a time: a tick that computes a heading
// goes in the back end through job capture, one CORDIC iteration per cycle, angle
// shift, two multiplies into one shared product register and the final clamp, and
// the back end takes the next job only once that command is loaded for output.
// A stop job skips the iterations, the angle shift and the multiplies, and a tick
// with x zero and y non-zero skips only the CORDIC iterations.
// The command output is registered: while the receiver stalls it holds, the back end
// finishes the next job and waits, and requests are taken until the queue fills.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data, one register per
// cycle, by the user only while the block is idle (not enforced). Reset clears the goal
// latch, age, waypoint flag, queue and output valid and loads the default configuration.
module waypoint_to_velocity_follower_top #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    wpf_req_if.sink     request,
    wpf_cmd_if.source   command,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import wpf_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    job_slot_t push;
    job_slot_t head;
    logic      full;
    logic      pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_LINEAR: cfg_next.max_linear    = cfg_data[30:0];
                CFG_MAX_TURN:   cfg_next.max_turn      = cfg_data[30:0];
                CFG_FRAME_RATE: cfg_next.frame_rate    = cfg_data[15:0];
                CFG_TIMEOUT:    cfg_next.timeout_ticks = cfg_data[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_linear    <= 31'd65536;
            cfg_reg.max_turn      <= 31'd65536;
            cfg_reg.frame_rate    <= 16'd1280;
            cfg_reg.timeout_ticks <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wpf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .request (request),
        .full    (full),
        .push    (push)
    );

    wpf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    wpf_back #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .pop     (pop),
        .command (command)
    );

endmodule

### verif/follower_sb_pkg.sv
// Command predictor and scoreboard for the waypoint follower testbench.
package follower_sb_pkg;
    import wpf_pkg::*;

    localparam longint HALF_TURN    = 205887;
    localparam longint QUARTER_TURN = 102944;
    localparam longint SAT_HI       = 64'sh7FFF_FFFF;
    localparam longint SAT_LO       = -64'sh8000_0000;
    localparam int     ROT_STEPS    = 16;
    localparam longint ROT_ANGLE [0:15] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        req_t               kind;
        logic               base;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               goal;
    } request_item_t;

    typedef struct {
        logic [30:0]        linear;
        logic signed [31:0] angular;
    } velocity_cmd_t;

    class command_scoreboard;
        logic [30:0]        max_lin;
        logic [30:0]        max_ang;
        logic [15:0]        rate;
        logic [15:0]        timeout;
        logic signed [31:0] wp_x;
        logic signed [31:0] wp_y;
        logic signed [15:0] wp_qz;
        logic signed [15:0] wp_qw;
        bit                 have_wp;
        bit                 goal_seen;
        logic [15:0]        age;
        velocity_cmd_t      expected_cmds[$];
        int                 errors;

        function new();
            max_lin   = 31'd65536;
            max_ang   = 31'd65536;
            rate      = 16'd1280;
            timeout   = 16'd10;
            wp_x      = '0;
            wp_y      = '0;
            wp_qz     = '0;
            wp_qw     = '0;
            have_wp   = 1'b0;
            goal_seen = 1'b0;
            age       = '0;
            errors    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_MAX_LINEAR: max_lin = value[30:0];
                CFG_MAX_TURN:   max_ang = value[30:0];
                CFG_FRAME_RATE: rate    = value[15:0];
                CFG_TIMEOUT:    timeout = value[15:0];
                default: ;
            endcase
        endfunction

        // vectoring rotation, angle in Q16.16 radians
        function longint heading(longint y, longint x);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            x = x * 65536;
            y = y * 65536;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ROT_ANGLE[i];
                end
                else if (y < 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ROT_ANGLE[i];
                end
            end
            return z;
        endfunction

        function longint scaled(longint v);
            longint p;
            p = (v * longint'(rate)) >>> 8;
            if (p > SAT_HI)
                return SAT_HI;
            if (p < SAT_LO)
                return SAT_LO;
            return p;
        endfunction

        function void take_request(request_item_t r);
            longint        lin;
            longint        ang;
            longint        x;
            longint        y;
            velocity_cmd_t c;
            case (r.kind)
                REQ_WAYPOINT:
                begin
                    if (r.base)
                    begin
                        wp_x    = r.x;
                        wp_y    = r.y;
                        wp_qz   = r.qz;
                        wp_qw   = r.qw;
                        age     = '0;
                        have_wp = 1'b1;
                    end
                end
                REQ_GOAL:
                begin
                    if (r.goal)
                        goal_seen = 1'b1;
                end
                REQ_TICK:
                begin
                    lin = 0;
                    ang = 0;
                    x   = wp_x;
                    y   = wp_y;
                    if (age != 16'hFFFF)
                        age = age + 16'd1;
                    if (!goal_seen && have_wp && age <= timeout)
                    begin
                        if (x == 0 && y == 0)
                            ang = scaled(2 * heading(wp_qz, wp_qw));
                        else if (x == 0)
                            ang = scaled((y > 0) ? QUARTER_TURN : -QUARTER_TURN);
                        else
                        begin
                            lin = scaled(x);
                            ang = (x < 0) ? scaled(heading(-y, -x)) : scaled(heading(y, x));
                        end
                        if (lin < 0)
                            lin = 0;
                        if (lin > longint'(max_lin))
                            lin = longint'(max_lin);
                        if (ang > longint'(max_ang))
                            ang = longint'(max_ang);
                        if (ang < -longint'(max_ang))
                            ang = -longint'(max_ang);
                    end
                    c.linear  = lin[30:0];
                    c.angular = ang[31:0];
                    expected_cmds.push_back(c);
                end
                default: ;
            endcase
        endfunction

        function void check_command(logic [30:0] lin, logic signed [31:0] ang);
            velocity_cmd_t c;
            if (expected_cmds.size() == 0)
            begin
                $error("command with no tick outstanding: linear_cmd %0d angular_cmd %0d",
                       lin, ang);
                errors++;
                return;
            end
            c = expected_cmds.pop_front();
            if (lin !== c.linear)
            begin
                $error("linear_cmd expected %0d got %0d", c.linear, lin);
                errors++;
            end
            if (ang !== c.angular)
            begin
                $error("angular_cmd expected %0d got %0d", c.angular, ang);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction
    endclass

endpackage

### verif/tb_top.sv
// Top-level testbench of the waypoint follower: clock, reset, drivers and run control.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpf_pkg::*;
    import follower_sb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    wpf_req_if req_ch ();
    wpf_cmd_if cmd_ch ();

    command_scoreboard sb;
    bit                no_gaps;
    int                hold_cycles;

    waypoint_to_velocity_follower_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .command   (cmd_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #30_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_request(input request_item_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.kind;
        req_ch.in_base_frame <= r.base;
        req_ch.pos_x         <= r.x;
        req_ch.pos_y         <= r.y;
        req_ch.quat_z        <= r.qz;
        req_ch.quat_w        <= r.qw;
        req_ch.goal_flag     <= r.goal;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        sb.take_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input req_t kind, input logic base,
                               input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [15:0] qz, input logic signed [15:0] qw,
                               input logic goal);
        request_item_t r;
        r.kind = kind;
        r.base = base;
        r.x    = x;
        r.y    = y;
        r.qz   = qz;
        r.qw   = qw;
        r.goal = goal;
        send_request(r);
    endtask

    task automatic take_commands();
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = no_gaps ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                cmd_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            cmd_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!cmd_ch.valid);
            sb.check_command(cmd_ch.linear_cmd, cmd_ch.angular_cmd);
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[30:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic settle(input int extra);
        req_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.outstanding() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic configure_phase(input int p);
        logic [31:0] lin_lim;
        logic [31:0] ang_lim;
        logic [31:0] rate;
        logic [31:0] tmo;
        case (p)
            0:
            begin
                lin_lim = 32'h7FFF_FFFF;
                ang_lim = 32'h7FFF_FFFF;
                rate    = 32'h0000_FFFF;
                tmo     = 32'h0000_FFFF;
            end
            1:
            begin
                lin_lim = '0;
                ang_lim = '0;
                rate    = '0;
                tmo     = '0;
            end
            2:
            begin
                lin_lim = 32'd1;
                ang_lim = 32'd1;
                rate    = 32'd1;
                tmo     = 32'd1;
            end
            default:
            begin
                lin_lim = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                                      : $urandom_range(1, 32'h6_0000);
                ang_lim = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                                      : $urandom_range(1, 32'h8_0000);
                rate    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16'hFFFF)
                                                      : $urandom_range(64, 2560);
                tmo     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                                      : $urandom_range(1, 30);
            end
        endcase
        write_reg(CFG_MAX_LINEAR, lin_lim);
        write_reg(CFG_MAX_TURN, ang_lim);
        write_reg(CFG_FRAME_RATE, rate);
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    function automatic logic signed [31:0] pick_offset();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sd0;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = 32'sh8000_0000;
            3, 4:    v = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh2_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] pick_quat();
        logic signed [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'sd0;
            1:       v = 16'sh7FFF;
            2:       v = 16'sh8000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic request_item_t random_request();
        request_item_t r;
        int            pick;
        pick   = $urandom_range(0, 99);
        r.kind = (pick < 22) ? REQ_WAYPOINT :
                 (pick < 27) ? REQ_GOAL :
                 (pick < 96) ? REQ_TICK : REQ_UNUSED;
        r.base = ($urandom_range(0, 9) != 0);
        r.x    = pick_offset();
        r.y    = pick_offset();
        if ($urandom_range(0, 9) == 0)
        begin
            r.x = '0;
            r.y = '0;
        end
        r.qz   = pick_quat();
        r.qw   = pick_quat();
        r.goal = 1'b0;
        return r;
    endfunction

    initial
    begin
        request_item_t r;
        int            sent;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_TICK;
        req_ch.in_base_frame = 1'b0;
        req_ch.pos_x         = '0;
        req_ch.pos_y         = '0;
        req_ch.quat_z        = '0;
        req_ch.quat_w        = '0;
        req_ch.goal_flag     = 1'b0;
        cmd_ch.ready         = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_MAX_LINEAR;
        cfg_data             = '0;
        no_gaps              = 1'b0;
        hold_cycles          = 0;
        sb                   = new();
        rst_n                = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        fork
            take_commands();
        join_none

        send_fields(REQ_TICK, 1'b1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_GOAL, 1'b1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b0, 32'sh1_0000, 32'sh1_0000, 16'sd0, 16'sh4000, 1'b0);
        send_fields(REQ_TICK, 1'b1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_UNUSED, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF,
                    1'b1);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sd0, 16'sh2D41, 16'sh2D41, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sd0, 16'sh8000, 16'sh7FFF, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sh3_0000, 16'sd0, 16'sh4000, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sd0, 32'sh8000_0000, 16'sd0, 16'sh4000, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sh4000,
                    1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sh4000,
                    1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sh0000_8000, 32'sh0000_4000, 16'sd0, 16'sh4000,
                    1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        settle(40);

        for (int p = 0; p < 8; p++)
        begin
            configure_phase(p);
            no_gaps = (p == 5);
            sent = 0;
            while (sent < 210)
            begin
                if (p == 3 && sent == 60)
                begin
                    hold_cycles = 400;
                    no_gaps = 1'b1;
                end
                if (p == 3 && sent == 100)
                    no_gaps = 1'b0;
                if (p == 4 && sent == 100)
                    settle(0);
                r = random_request();
                send_request(r);
                if (r.kind != REQ_UNUSED && !(r.kind == REQ_WAYPOINT && !r.base))
                    sent++;
            end
            settle(40);
        end

        send_fields(REQ_WAYPOINT, 1'b1, 32'sh2_0000, 32'sh1_0000, 16'sd0, 16'sh4000, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_GOAL, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b1);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_WAYPOINT, 1'b1, 32'sh1_0000, 32'sd0, 16'sd0, 16'sh4000, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_GOAL, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        send_fields(REQ_TICK, 1'b0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0);
        settle(40);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
